>>> hw/rtl/rgbae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbae_pkg
// Constants shared by the colour escape unit: the 16 base colours of the
// xterm palette, the fixed characters of the escape sequence and the index constants.
// ----------------------------------------------------------------------------
package rgbae_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  digit_t;
  typedef logic [23:0] rgb_t;

  // base colours, packed as red, green, blue
  localparam rgb_t PALETTE16 [16] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
    24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
  };

  // characters of the sequence
  localparam byte_t CH_ESC   = 8'h1b;
  localparam byte_t CH_LBRKT = 8'h5b;
  localparam byte_t CH_THREE = 8'h33;
  localparam byte_t CH_FOUR  = 8'h34;
  localparam byte_t CH_EIGHT = 8'h38;
  localparam byte_t CH_SEMI  = 8'h3b;
  localparam byte_t CH_FIVE  = 8'h35;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_M     = 8'h6d;

  // number of bytes ahead of the decimal index
  localparam logic [3:0] PREFIX_LEN = 4'd7;

  // grey ramp and colour cube constants
  localparam logic [7:0] GREY_BASE = 8'd231;
  localparam logic [4:0] GREY_TOP  = 5'd25;
  localparam logic [7:0] WHITE_IDX = 8'd15;
  localparam logic [7:0] CUBE_BASE = 8'd16;

endpackage

>>> hw/rtl/rgb_to_ansi256_escape_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ansi256_escape_unit
// Maps an RGB colour to an xterm 256-colour index and sends the matching
// escape sequence ESC [ 3|4 8 ; 5 ; <index> m one byte per transfer.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   foreground, red, green, blue
//  output   out        out_valid/out_stall out_byte, last
//
// An item is sent as 9, 10 or 11 bytes (one, two or three index digits);
// the byte serialiser sets the rate. An input register holds the next item
// while the serialiser sends the current one, so items follow with no gap.
// An input item is held in the input register, then in the serialiser register, before its first byte goes out.
// Reset clears both valid flags; a stall on the output freezes the sequence.
// ----------------------------------------------------------------------------
module rgb_to_ansi256_escape_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               foreground,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               out_valid,
  input  logic               out_stall,
  output rgbae_pkg::byte_t   out_byte,
  output logic               last
);
  import rgbae_pkg::*;

  // input register
  logic       s1_valid;
  logic       s1_fg;
  logic [7:0] s1_r, s1_g, s1_b;

  // serialiser register
  logic       s2_valid;
  logic       s2_fg;
  digit_t     s2_dig [3];
  logic [1:0] s2_ndig;
  logic [3:0] pos;

  logic in_fire, out_fire, s2_load;

  // ---------------------------------------------------------------- index
  logic        pal_hit;
  logic [3:0]  pal_idx;
  logic [10:0] grey_x5;
  logic [21:0] grey_prod;
  logic [4:0]  grey_v;
  logic [2:0]  cr, cg, cb;
  logic [7:0]  idx;

  // component scaled to 0..5, c*5/255 = c/51
  function automatic logic [2:0] cube_level(input logic [7:0] c);
    logic [2:0] l;
    if (c == 8'd255)      l = 3'd5;
    else if (c >= 8'd204) l = 3'd4;
    else if (c >= 8'd153) l = 3'd3;
    else if (c >= 8'd102) l = 3'd2;
    else if (c >= 8'd51)  l = 3'd1;
    else                  l = 3'd0;
    return l;
  endfunction

  always_comb begin
    pal_hit = 1'b0;
    pal_idx = '0;
    for (int i = 0; i < 16; i++) begin
      if ({s1_r, s1_g, s1_b} == PALETTE16[i] && !pal_hit) begin
        pal_hit = 1'b1;
        pal_idx = 4'(i);
      end
    end
  end

  // grey: r*25/255 = (r*5)/51, reciprocal 1286/65536 is exact here
  assign grey_x5   = {3'b000, s1_r} + {1'b0, s1_r, 2'b00};
  assign grey_prod = {11'd0, grey_x5} * 22'd1286;
  assign grey_v    = grey_prod[20:16];

  assign cr = cube_level(s1_r);
  assign cg = cube_level(s1_g);
  assign cb = cube_level(s1_b);

  always_comb begin
    if (pal_hit) begin
      idx = {4'd0, pal_idx};
    end else if (s1_r == s1_g && s1_r == s1_b) begin
      if (grey_v == 5'd0)          idx = 8'd0;
      else if (grey_v == GREY_TOP) idx = WHITE_IDX;
      else                         idx = GREY_BASE + {3'd0, grey_v};
    end else begin
      idx = CUBE_BASE + 8'd36 * {5'd0, cr} + 8'd6 * {5'd0, cg} + {5'd0, cb};
    end
  end

  // ---------------------------------------------------------------- digits
  logic [1:0]  d_hund;
  logic [6:0]  d_rem;
  logic [14:0] d_prod;
  logic [3:0]  d_tens, d_ones;
  logic [1:0]  d_ndig;
  digit_t      d_dig [3];

  always_comb begin
    if (idx >= 8'd200) begin
      d_hund = 2'd2;
      d_rem  = 7'(idx - 8'd200);
    end else if (idx >= 8'd100) begin
      d_hund = 2'd1;
      d_rem  = 7'(idx - 8'd100);
    end else begin
      d_hund = 2'd0;
      d_rem  = idx[6:0];
    end
    // x/10 as x*205 >> 11 for x below 100
    d_prod = {8'd0, d_rem} * 15'd205;
    d_tens = d_prod[14:11];
    d_ones = 4'(d_rem - {3'd0, d_tens} * 7'd10);
    // digits left-justified
    if (idx >= 8'd100) begin
      d_ndig   = 2'd3;
      d_dig[0] = {2'b00, d_hund};
      d_dig[1] = d_tens;
      d_dig[2] = d_ones;
    end else if (idx >= 8'd10) begin
      d_ndig   = 2'd2;
      d_dig[0] = d_tens;
      d_dig[1] = d_ones;
      d_dig[2] = '0;
    end else begin
      d_ndig   = 2'd1;
      d_dig[0] = d_ones;
      d_dig[1] = '0;
      d_dig[2] = '0;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic [3:0] end_pos;
  logic [3:0] dig_pos;

  assign end_pos   = PREFIX_LEN + {2'b00, s2_ndig};
  assign last      = (pos == end_pos);
  assign out_valid = s2_valid;
  assign out_fire  = s2_valid && !out_stall;
  assign s2_load   = s1_valid && (!s2_valid || (out_fire && last));
  assign in_stall  = s1_valid && !s2_load;
  assign in_fire   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_fg <= foreground;
      s1_r  <= red;
      s1_g  <= green;
      s1_b  <= blue;
    end
  end

  // serialiser register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      pos      <= '0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
      pos      <= '0;
    end else if (out_fire) begin
      if (last) begin
        s2_valid <= 1'b0;
        pos      <= '0;
      end else begin
        pos <= pos + 4'd1;
      end
    end
    if (s2_load) begin
      s2_fg   <= s1_fg;
      s2_ndig <= d_ndig;
      s2_dig  <= d_dig;
    end
  end

  // ---------------------------------------------------------------- byte select
  assign dig_pos = pos - PREFIX_LEN;

  always_comb begin
    case (pos)
      4'd0:    out_byte = CH_ESC;
      4'd1:    out_byte = CH_LBRKT;
      4'd2:    out_byte = s2_fg ? CH_THREE : CH_FOUR;
      4'd3:    out_byte = CH_EIGHT;
      4'd4:    out_byte = CH_SEMI;
      4'd5:    out_byte = CH_FIVE;
      4'd6:    out_byte = CH_SEMI;
      default: begin
        if (last || dig_pos > 4'd2) out_byte = CH_M;
        else out_byte = CH_ZERO + {4'd0, s2_dig[dig_pos[1:0]]};
      end
    endcase
  end

endmodule
